>>> rtl/knn_majority_classifier_defines.svh
// Assertion macros shared by the classifier RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the user scope.
`ifndef KNN_MAJORITY_CLASSIFIER_DEFINES_SVH
`define KNN_MAJORITY_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KNN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KNN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/knn_pkg.sv
// Shared constants, codes and types of the k-nearest-neighbor classifier.
// No dependencies.
package knn_pkg;

  localparam int MAX_POINTS_DEF   = 64;
  localparam int MAX_FEATURES_DEF = 8;
  localparam int NUM_LABELS_DEF   = 16;
  localparam int FEATURE_BITS_DEF = 16;

  localparam int OP_W       = 2;
  localparam int K_W        = 7;
  localparam int NF_W       = 4;
  localparam int CAP_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [OP_W-1:0] OP_TRAIN   = 2'd0;
  localparam logic [OP_W-1:0] OP_PREDICT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_K   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP = 2'd2;

  localparam logic [K_W-1:0]   K_RESET   = 7'd3;
  localparam logic [NF_W-1:0]  NF_RESET  = 4'd8;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } sq_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sq_stat_t;

  // Width of a distance sum; capped at 64 bits, where the sum saturates.
  function automatic int dsum_w(int fb, int mf);
    int w;
    w = 2 * fb + $clog2(mf);
    return (w > 64) ? 64 : w;
  endfunction

endpackage

>>> rtl/knn_chan_if.sv
// Valid/ready channel interfaces for the classifier input and result words.
// Depends on knn_pkg.
interface knn_in_if #(
  parameter int FEAT_W = knn_pkg::FEATURE_BITS_DEF,
  parameter int LBL_W  = $clog2(knn_pkg::NUM_LABELS_DEF)
);
  logic                     valid;
  logic                     ready;
  logic [knn_pkg::OP_W-1:0] operation;
  logic signed [FEAT_W-1:0] feature_value;
  logic [LBL_W-1:0]         label;

  modport source(output valid, operation, feature_value, label, input ready);
  modport sink(input valid, operation, feature_value, label, output ready);
endinterface

interface knn_out_if #(
  parameter int LBL_W = $clog2(knn_pkg::NUM_LABELS_DEF)
);
  logic             valid;
  logic             ready;
  logic [LBL_W-1:0] predicted_label;
  logic             no_data;

  modport source(output valid, predicted_label, no_data, input ready);
  modport sink(input valid, predicted_label, no_data, output ready);
endinterface

>>> rtl/knn_majority_classifier.sv
// Top level of the k-nearest-neighbor majority classifier: sequencer and memories.
// Depends on knn_pkg, knn_chan_if, knn_sq_acc and knn_majority_classifier_defines.svh.
//
// Words arrive one feature at a time. A train vector's last word starts a store sweep
// into the feature memory. A predict vector's last word starts a classification over
// the n stored points: a pass to clear the vote memory, a stream of every stored
// feature through the squared-distance pipeline, then a ranking pass, for each voting
// point a read of its label and a read and increment of that label's vote, a scan to
// pick the winning label and a load of the result. The ranking pass dominates for a
// full store; it is set by the single read port of the distance memory, which is swept
// once per stored point. An empty store answers in the cycle after the word with
// no_data set. Ties in distance go to the earlier-stored point and ties in votes to the
// smaller label. Input is held off while a result waits to be taken or the sequencer
// is busy. Memories need no clearing pass after reset.
`include "knn_majority_classifier_defines.svh"

module knn_majority_classifier #(
  parameter int MAX_POINTS   = knn_pkg::MAX_POINTS_DEF,
  parameter int MAX_FEATURES = knn_pkg::MAX_FEATURES_DEF,
  parameter int NUM_LABELS   = knn_pkg::NUM_LABELS_DEF,
  parameter int FEATURE_BITS = knn_pkg::FEATURE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  knn_in_if.sink                          in_if,
  knn_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [knn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [knn_pkg::CFG_DATA_W-1:0]  cfg_data
);
  localparam int FIDX_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int FCNT_W  = $clog2(MAX_FEATURES + 1);
  localparam int PIDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PCNT_W  = $clog2(MAX_POINTS + 1);
  localparam int FDEPTH  = MAX_POINTS * MAX_FEATURES;
  localparam int FADDR_W = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
  localparam int LBL_W   = $clog2(NUM_LABELS);
  localparam int LCNT_W  = $clog2(NUM_LABELS + 1);
  localparam int DSUM_W  = knn_pkg::dsum_w(FEATURE_BITS, MAX_FEATURES);

  typedef enum logic [3:0] {
    ST_IDLE, ST_STORE, ST_VCLR, ST_DIST, ST_RLOAD, ST_RPIV, ST_RSWEEP,
    ST_VLAB, ST_VCNT, ST_VINC, ST_SCAN, ST_FIN
  } state_t;

  // Memories
  logic [FEATURE_BITS-1:0] fmem [FDEPTH];
  logic [DSUM_W-1:0]       dmem [MAX_POINTS];
  logic [LBL_W-1:0]        lmem [MAX_POINTS];
  logic [PCNT_W-1:0]       vmem [NUM_LABELS];
  logic [FEATURE_BITS-1:0] fmem_rd_r;
  logic [DSUM_W-1:0]       dmem_rd_r;
  logic [LBL_W-1:0]        lmem_rd_r;
  logic [PCNT_W-1:0]       vmem_rd_r;

  logic                    fmem_we;
  logic [FADDR_W-1:0]      fmem_wa, fmem_ra;
  logic [FEATURE_BITS-1:0] fmem_wd;
  logic                    dmem_we;
  logic [PIDX_W-1:0]       dmem_wa, dmem_ra;
  logic                    lmem_we;
  logic [PIDX_W-1:0]       lmem_wa, lmem_ra;
  logic                    vmem_we;
  logic [LBL_W-1:0]        vmem_wa, vmem_ra;
  logic [PCNT_W-1:0]       vmem_wd;

  // Query buffer
  logic [FEATURE_BITS-1:0] qb_r [MAX_FEATURES];
  logic                    qb_we;
  logic [FIDX_W-1:0]       qb_wa;

  // Control and datapath registers
  state_t                state_r, state_nxt;
  logic [knn_pkg::K_W-1:0]   k_r, k_nxt;
  logic [knn_pkg::NF_W-1:0]  nf_r, nf_nxt;
  logic [knn_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic [PCNT_W-1:0]     cnt_r, cnt_nxt;
  logic [PIDX_W-1:0]     old_r, old_nxt;
  logic [FIDX_W-1:0]     pos_r, pos_nxt;
  logic [PIDX_W-1:0]     slot_r, slot_nxt;
  logic [LBL_W-1:0]      lbl_r, lbl_nxt;
  logic [FCNT_W-1:0]     f_r, f_nxt;
  logic [PCNT_W-1:0]     n_r, n_nxt;
  logic [PCNT_W-1:0]     ip_r, ip_nxt;
  logic [PIDX_W-1:0]     pslot_r, pslot_nxt;
  knn_pkg::sq_ctl_t      s1_r, s1_nxt;
  logic [FIDX_W-1:0]     s1f_r, s1f_nxt;
  logic [PCNT_W-1:0]     wp_r, wp_nxt;
  logic [PCNT_W-1:0]     p_r, p_nxt;
  logic [PIDX_W-1:0]     vslot_r, vslot_nxt;
  logic [DSUM_W-1:0]     dp_r, dp_nxt;
  logic [PCNT_W-1:0]     qi_r, qi_nxt;
  logic                  cv_r, cv_nxt;
  logic [PCNT_W-1:0]     cq_r, cq_nxt;
  logic [PCNT_W-1:0]     rank_r, rank_nxt;
  logic [LBL_W-1:0]      labq_r, labq_nxt;
  logic [LCNT_W-1:0]     si_r, si_nxt;
  logic                  sv_r, sv_nxt;
  logic [LBL_W-1:0]      sl_r, sl_nxt;
  logic [LBL_W-1:0]      best_r, best_nxt;
  logic [PCNT_W-1:0]     bv_r, bv_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [LBL_W-1:0]      out_lbl_r, out_lbl_nxt;
  logic                  out_nd_r, out_nd_nxt;

  // Derived values
  logic [FCNT_W-1:0]     nf_used;
  logic [PCNT_W-1:0]     cap_used;
  logic [PCNT_W-1:0]     k_used;
  logic [PCNT_W-1:0]     cnt_n;
  logic [PIDX_W-1:0]     old_n;
  logic [PCNT_W:0]       slot_sum;
  logic [PIDX_W-1:0]     new_slot;
  logic [PIDX_W-1:0]     old_inc;
  logic [FIDX_W-1:0]     pos_eff;
  logic                  in_acc;
  logic                  out_load;
  logic                  closer;
  logic                  ready_int;
  knn_pkg::sq_stat_t     sq_stat;
  logic [DSUM_W-1:0]     sq_sum;

  always_comb begin
    if (nf_r == '0) nf_used = FCNT_W'(1);
    else if (32'(nf_r) > 32'(MAX_FEATURES)) nf_used = FCNT_W'(MAX_FEATURES);
    else nf_used = FCNT_W'(nf_r);

    if (cap_r == '0) cap_used = PCNT_W'(1);
    else if (32'(cap_r) > 32'(MAX_POINTS)) cap_used = PCNT_W'(MAX_POINTS);
    else cap_used = PCNT_W'(cap_r);

    if (k_r == '0) k_used = PCNT_W'(1);
    else if (32'(k_r) > 32'(n_r)) k_used = n_r;
    else k_used = PCNT_W'(k_r);

    // Drop a store left inconsistent by a smaller capacity.
    if (cnt_r > cap_used || PCNT_W'(old_r) >= cap_used) begin
      cnt_n = '0;
      old_n = '0;
    end else begin
      cnt_n = cnt_r;
      old_n = old_r;
    end
    slot_sum = (PCNT_W+1)'(old_n) + (PCNT_W+1)'(cnt_n);
    if (slot_sum >= (PCNT_W+1)'(cap_used)) slot_sum = slot_sum - (PCNT_W+1)'(cap_used);
    new_slot = (cnt_n < cap_used) ? PIDX_W'(slot_sum) : old_n;
    old_inc  = (PCNT_W'(old_n) + PCNT_W'(1) == cap_used) ? '0 : PIDX_W'(old_n + 1'b1);

    pos_eff = (FCNT_W'(pos_r) >= nf_used) ? '0 : pos_r;
  end

  assign ready_int      = (state_r == ST_IDLE) && (!out_valid_r || out_if.ready);
  assign in_if.ready    = ready_int;
  assign in_acc         = in_if.valid && ready_int;
  assign closer         = (dmem_rd_r < dp_r) || ((dmem_rd_r == dp_r) && (cq_r < p_r));

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r; nf_nxt = nf_r; cap_nxt = cap_r;
    cnt_nxt = cnt_r; old_nxt = old_r; pos_nxt = pos_r;
    slot_nxt = slot_r; lbl_nxt = lbl_r; f_nxt = f_r; n_nxt = n_r;
    ip_nxt = ip_r; pslot_nxt = pslot_r;
    s1_nxt = '0; s1f_nxt = s1f_r;
    wp_nxt = wp_r; p_nxt = p_r; vslot_nxt = vslot_r; dp_nxt = dp_r;
    qi_nxt = qi_r; cv_nxt = 1'b0; cq_nxt = cq_r; rank_nxt = rank_r;
    labq_nxt = labq_r; si_nxt = si_r; sv_nxt = 1'b0; sl_nxt = sl_r;
    best_nxt = best_r; bv_nxt = bv_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_lbl_nxt = out_lbl_r; out_nd_nxt = out_nd_r;
    out_load = 1'b0;

    qb_we = 1'b0; qb_wa = pos_eff;
    fmem_we = 1'b0; fmem_wa = '0; fmem_wd = '0; fmem_ra = '0;
    dmem_we = sq_stat.done; dmem_wa = wp_r[PIDX_W-1:0]; dmem_ra = '0;
    lmem_we = 1'b0; lmem_wa = slot_r; lmem_ra = vslot_r;
    vmem_we = 1'b0; vmem_wa = '0; vmem_wd = '0; vmem_ra = '0;

    if (sq_stat.done) wp_nxt = wp_r + 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_if.operation) inside
            knn_pkg::OP_CLEAR: begin
              cnt_nxt = '0;
              old_nxt = '0;
              pos_nxt = '0;
            end
            knn_pkg::OP_TRAIN, knn_pkg::OP_PREDICT: begin
              qb_we = 1'b1;
              if (FCNT_W'(pos_eff) + FCNT_W'(1) < nf_used) begin
                pos_nxt = pos_eff + 1'b1;
              end else begin
                pos_nxt = '0;
                cnt_nxt = cnt_n;
                old_nxt = old_n;
                if (in_if.operation == knn_pkg::OP_TRAIN) begin
                  if (cnt_n < cap_used) cnt_nxt = cnt_n + 1'b1;
                  else old_nxt = old_inc;
                  slot_nxt = new_slot;
                  lbl_nxt  = (32'(in_if.label) >= NUM_LABELS) ?
                             LBL_W'(NUM_LABELS - 1) : in_if.label;
                  f_nxt     = '0;
                  state_nxt = ST_STORE;
                end else if (cnt_n == '0) begin
                  out_load    = 1'b1;
                  out_lbl_nxt = '0;
                  out_nd_nxt  = 1'b1;
                end else begin
                  n_nxt     = cnt_n;
                  si_nxt    = '0;
                  state_nxt = ST_VCLR;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_STORE: begin
        // Write one feature per cycle; pad unused features with zero.
        fmem_we = 1'b1;
        fmem_wa = FADDR_W'(32'(slot_r) * MAX_FEATURES + 32'(f_r));
        fmem_wd = (f_r < nf_used) ? qb_r[f_r[FIDX_W-1:0]] : '0;
        lmem_we = 1'b1;
        f_nxt   = f_r + 1'b1;
        if (f_r == FCNT_W'(MAX_FEATURES - 1)) state_nxt = ST_IDLE;
      end
      ST_VCLR: begin
        vmem_we = 1'b1;
        vmem_wa = si_r[LBL_W-1:0];
        si_nxt  = si_r + 1'b1;
        if (si_r == LCNT_W'(NUM_LABELS - 1)) begin
          ip_nxt    = '0;
          f_nxt     = '0;
          pslot_nxt = old_r;
          wp_nxt    = '0;
          state_nxt = ST_DIST;
        end
      end
      ST_DIST: begin
        if (ip_r < n_r) begin
          fmem_ra      = FADDR_W'(32'(pslot_r) * MAX_FEATURES + 32'(f_r));
          s1_nxt.valid = 1'b1;
          s1_nxt.first = (f_r == '0);
          s1_nxt.last  = (f_r + FCNT_W'(1) == nf_used);
          s1f_nxt      = f_r[FIDX_W-1:0];
          if (f_r + FCNT_W'(1) == nf_used) begin
            f_nxt     = '0;
            ip_nxt    = ip_r + 1'b1;
            pslot_nxt = (PCNT_W'(pslot_r) + PCNT_W'(1) == cap_used) ? '0 : pslot_r + 1'b1;
          end else begin
            f_nxt = f_r + 1'b1;
          end
        end else if (!s1_r.valid && !sq_stat.busy) begin
          p_nxt     = '0;
          vslot_nxt = old_r;
          state_nxt = ST_RLOAD;
        end
      end
      ST_RLOAD: begin
        dmem_ra   = p_r[PIDX_W-1:0];
        state_nxt = ST_RPIV;
      end
      ST_RPIV: begin
        dp_nxt    = dmem_rd_r;
        dmem_ra   = '0;
        cv_nxt    = 1'b1;
        cq_nxt    = '0;
        qi_nxt    = PCNT_W'(1);
        rank_nxt  = '0;
        state_nxt = ST_RSWEEP;
      end
      ST_RSWEEP: begin
        // Count stored points that rank ahead of point p.
        if (cv_r && closer) rank_nxt = rank_r + 1'b1;
        if (qi_r < n_r) begin
          dmem_ra = qi_r[PIDX_W-1:0];
          cv_nxt  = 1'b1;
          cq_nxt  = qi_r;
          qi_nxt  = qi_r + 1'b1;
        end else if (!cv_r) begin
          if (rank_r < k_used) begin
            state_nxt = ST_VLAB;
          end else begin
            p_nxt     = p_r + 1'b1;
            vslot_nxt = (PCNT_W'(vslot_r) + PCNT_W'(1) == cap_used) ? '0 : vslot_r + 1'b1;
            if (p_r + PCNT_W'(1) == n_r) begin
              si_nxt    = '0;
              best_nxt  = '0;
              bv_nxt    = '0;
              state_nxt = ST_SCAN;
            end else begin
              state_nxt = ST_RLOAD;
            end
          end
        end
      end
      ST_VLAB: begin
        lmem_ra   = vslot_r;
        state_nxt = ST_VCNT;
      end
      ST_VCNT: begin
        vmem_ra   = lmem_rd_r;
        labq_nxt  = lmem_rd_r;
        state_nxt = ST_VINC;
      end
      ST_VINC: begin
        vmem_we   = 1'b1;
        vmem_wa   = labq_r;
        vmem_wd   = vmem_rd_r + 1'b1;
        p_nxt     = p_r + 1'b1;
        vslot_nxt = (PCNT_W'(vslot_r) + PCNT_W'(1) == cap_used) ? '0 : vslot_r + 1'b1;
        if (p_r + PCNT_W'(1) == n_r) begin
          si_nxt    = '0;
          best_nxt  = '0;
          bv_nxt    = '0;
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_RLOAD;
        end
      end
      ST_SCAN: begin
        // Strict compare keeps the smallest label on a tie.
        if (sv_r && vmem_rd_r > bv_r) begin
          bv_nxt   = vmem_rd_r;
          best_nxt = sl_r;
        end
        if (si_r < LCNT_W'(NUM_LABELS)) begin
          vmem_ra = si_r[LBL_W-1:0];
          sv_nxt  = 1'b1;
          sl_nxt  = si_r[LBL_W-1:0];
          si_nxt  = si_r + 1'b1;
        end else if (!sv_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_if.ready) begin
          out_load    = 1'b1;
          out_lbl_nxt = best_r;
          out_nd_nxt  = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (out_load) out_valid_nxt = 1'b1;

    if (cfg_we) begin
      unique case (cfg_index)
        knn_pkg::CFG_K:   k_nxt = knn_pkg::K_W'(cfg_data);
        knn_pkg::CFG_NF: begin
          nf_nxt  = knn_pkg::NF_W'(cfg_data);
          pos_nxt = '0;
        end
        knn_pkg::CFG_CAP: begin
          cap_nxt = knn_pkg::CAP_W'(cfg_data);
          cnt_nxt = '0;
          old_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= knn_pkg::K_RESET;
      nf_r        <= knn_pkg::NF_RESET;
      cap_r       <= knn_pkg::CAP_RESET;
      cnt_r       <= '0;
      old_r       <= '0;
      pos_r       <= '0;
      s1_r        <= '0;
      cv_r        <= 1'b0;
      sv_r        <= 1'b0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      nf_r        <= nf_nxt;
      cap_r       <= cap_nxt;
      cnt_r       <= cnt_nxt;
      old_r       <= old_nxt;
      pos_r       <= pos_nxt;
      s1_r        <= s1_nxt;
      cv_r        <= cv_nxt;
      sv_r        <= sv_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r    <= slot_nxt;
    lbl_r     <= lbl_nxt;
    f_r       <= f_nxt;
    n_r       <= n_nxt;
    ip_r      <= ip_nxt;
    pslot_r   <= pslot_nxt;
    s1f_r     <= s1f_nxt;
    p_r       <= p_nxt;
    vslot_r   <= vslot_nxt;
    dp_r      <= dp_nxt;
    qi_r      <= qi_nxt;
    cq_r      <= cq_nxt;
    rank_r    <= rank_nxt;
    labq_r    <= labq_nxt;
    si_r      <= si_nxt;
    sl_r      <= sl_nxt;
    best_r    <= best_nxt;
    bv_r      <= bv_nxt;
    out_lbl_r <= out_lbl_nxt;
    out_nd_r  <= out_nd_nxt;
  end

  // Memories: one write and one registered read each; the query buffer is read combinationally.
  always_ff @(posedge clk) begin
    if (qb_we) qb_r[qb_wa] <= in_if.feature_value;
  end

  always_ff @(posedge clk) begin
    if (fmem_we) fmem[fmem_wa] <= fmem_wd;
    fmem_rd_r <= fmem[fmem_ra];
  end

  always_ff @(posedge clk) begin
    if (dmem_we) dmem[dmem_wa] <= sq_sum;
    dmem_rd_r <= dmem[dmem_ra];
  end

  always_ff @(posedge clk) begin
    if (lmem_we) lmem[lmem_wa] <= lbl_r;
    lmem_rd_r <= lmem[lmem_ra];
  end

  // Each vote is read in ST_VCNT and written back in the following ST_VINC; no overlap.
  always_ff @(posedge clk) begin
    if (vmem_we) vmem[vmem_wa] <= vmem_wd;
    vmem_rd_r <= vmem[vmem_ra];
  end

  knn_sq_acc #(
    .FEATURE_BITS (FEATURE_BITS),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_sq_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (s1_r),
    .query_i  (qb_r[s1f_r]),
    .stored_i (fmem_rd_r),
    .stat_o   (sq_stat),
    .sum_o    (sq_sum)
  );

  assign out_if.valid           = out_valid_r;
  assign out_if.predicted_label = out_lbl_r;
  assign out_if.no_data         = out_nd_r;

  `KNN_ASSERT_NOW(a_dist_count, state_r == ST_RLOAD, wp_r == n_r, "distance count mismatch")
  `KNN_ASSERT_NOW(a_out_free, out_load, !out_valid_r || out_if.ready, "result overwritten")
  `KNN_ASSERT_NOW(a_votes_le_k, state_r == ST_FIN, bv_r <= k_used, "votes exceed k")
  `KNN_ASSERT_NEXT(a_vinc_order, state_r == ST_VCNT, state_r == ST_VINC, "vote update skipped")
endmodule

>>> rtl/knn_sq_acc.sv
// Squared-difference and saturating accumulate stages of the distance datapath.
// Depends on knn_pkg.
module knn_sq_acc #(
  parameter int FEATURE_BITS = knn_pkg::FEATURE_BITS_DEF,
  parameter int MAX_FEATURES = knn_pkg::MAX_FEATURES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  knn_pkg::sq_ctl_t       ctl_i,
  input  logic [FEATURE_BITS-1:0] query_i,
  input  logic [FEATURE_BITS-1:0] stored_i,
  output knn_pkg::sq_stat_t      stat_o,
  output logic [knn_pkg::dsum_w(FEATURE_BITS, MAX_FEATURES)-1:0] sum_o
);
  localparam int SQ_W   = 2 * FEATURE_BITS;
  localparam int DSUM_W = knn_pkg::dsum_w(FEATURE_BITS, MAX_FEATURES);

  logic signed [FEATURE_BITS:0]     diff;
  logic signed [2*FEATURE_BITS+1:0] prod;
  knn_pkg::sq_ctl_t                 ctl2_r;
  logic [SQ_W-1:0]                  sq_r;
  logic [DSUM_W-1:0]                acc_r;
  logic [DSUM_W-1:0]                acc_nxt;
  logic [DSUM_W-1:0]                base;
  logic [DSUM_W:0]                  wide;
  logic                             done_r;

  assign diff = $signed({query_i[FEATURE_BITS-1], query_i})
              - $signed({stored_i[FEATURE_BITS-1], stored_i});
  assign prod = diff * diff;

  // Saturate at all ones on carry out.
  always_comb begin
    base    = ctl2_r.first ? '0 : acc_r;
    wide    = {1'b0, base} + (DSUM_W+1)'(sq_r);
    acc_nxt = wide[DSUM_W] ? '1 : wide[DSUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
      done_r <= 1'b0;
    end else begin
      ctl2_r <= ctl_i;
      done_r <= ctl2_r.valid && ctl2_r.last;
    end
    sq_r <= prod[SQ_W-1:0];
    if (ctl2_r.valid) acc_r <= acc_nxt;
  end

  assign stat_o.busy = ctl2_r.valid || done_r;
  assign stat_o.done = done_r;
  assign sum_o       = acc_r;
endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for knn_majority_classifier: directed table, then random phases.
// Depends on knn_pkg, knn_in_if / knn_out_if and the classifier RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int NPTS      = knn_pkg::MAX_POINTS_DEF;
  localparam int NFEAT     = knn_pkg::MAX_FEATURES_DEF;
  localparam int NLBL      = knn_pkg::NUM_LABELS_DEF;
  localparam int IDLE_LIM  = 20000;  // watchdog limit, well above a full-store classify
  localparam int SETTLE    = 64;     // store sweep plus margin before a register write
  localparam int RAND_ITEMS = 1600;

  typedef struct {
    logic [3:0] lbl;
    bit         nd;
  } verdict_t;

  // One row of the directed table: either a register write or an input word.
  typedef struct {
    bit                 is_cfg;
    logic [1:0]         code;
    logic signed [15:0] val;
    logic [3:0]         lab;
    bit                 typed;
    logic [3:0]         exp_lbl;
    bit                 exp_nd;
  } drow_t;

  logic clk;
  logic rst_n;
  logic                           cfg_we;
  logic [knn_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [knn_pkg::CFG_DATA_W-1:0] cfg_data;

  knn_in_if  in_ch ();
  knn_out_if out_ch ();

  knn_majority_classifier u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the classifier: registers, stores and the feature gatherer.
  // ---------------------------------------------------------------------------
  int unsigned sh_k, sh_nf, sh_cap;
  logic [15:0] pt_feat [NPTS][NFEAT];
  logic [3:0]  pt_lbl [NPTS];
  logic [15:0] query [NFEAT];
  int unsigned oldest, npts, fpos;

  verdict_t pending_verdicts[$];
  int fails;
  int n_verdicts, n_nodata, n_trained, n_words;

  function automatic int unsigned feat_in_use();
    if (sh_nf == 0) return 1;
    return (sh_nf > NFEAT) ? NFEAT : sh_nf;
  endfunction

  function automatic int unsigned ring_size();
    if (sh_cap == 0) return 1;
    return (sh_cap > NPTS) ? NPTS : sh_cap;
  endfunction

  function automatic void store_point(logic [3:0] lab);
    int unsigned cap, slot;
    cap = ring_size();
    if (npts > cap || oldest >= cap) begin
      oldest = 0;
      npts = 0;
    end
    if (npts < cap) begin
      slot = (oldest + npts) % cap;
      npts++;
    end else begin
      slot = oldest;
      oldest = (oldest + 1) % cap;
    end
    for (int f = 0; f < NFEAT; f++) pt_feat[slot][f] = (f < feat_in_use()) ? query[f] : '0;
    pt_lbl[slot] = lab;
    n_trained++;
  endfunction

  // Majority label among the k nearest stored points; earlier point wins a distance tie,
  // smaller label wins a vote tie.
  function automatic logic [3:0] vote_nearest();
    longint unsigned dsq [NPTS];
    int unsigned votes [NLBL];
    int unsigned cap, nf, k, rank, slot, best, best_votes;
    longint signed d;
    cap = ring_size();
    nf = feat_in_use();
    for (int p = 0; p < npts; p++) begin
      slot = (oldest + p) % cap;
      dsq[p] = 0;
      for (int f = 0; f < nf; f++) begin
        d = longint'($signed(query[f])) - longint'($signed(pt_feat[slot][f]));
        dsq[p] += longint'(d * d);
      end
    end
    k = (sh_k == 0) ? 1 : ((sh_k > npts) ? npts : sh_k);
    for (int l = 0; l < NLBL; l++) votes[l] = 0;
    for (int p = 0; p < npts; p++) begin
      rank = 0;
      for (int q = 0; q < npts; q++)
        if (dsq[q] < dsq[p] || (dsq[q] == dsq[p] && q < p)) rank++;
      if (rank < k) votes[pt_lbl[(oldest + p) % cap]]++;
    end
    best = 0;
    best_votes = 0;
    for (int l = 0; l < NLBL; l++)
      if (votes[l] > best_votes) begin
        best_votes = votes[l];
        best = l;
      end
    return best[3:0];
  endfunction

  // Advance the shadow by one accepted word; returns 1 with a verdict when a predict completes.
  function automatic bit absorb_word(logic [1:0] op, logic [15:0] fv, logic [3:0] lab,
                                     output verdict_t v);
    int unsigned nf, p;
    v = '{lbl: '0, nd: 1'b0};
    if (op == knn_pkg::OP_NONE) return 0;
    if (op == knn_pkg::OP_CLEAR) begin
      oldest = 0;
      npts = 0;
      fpos = 0;
      return 0;
    end
    nf = feat_in_use();
    p = (fpos >= nf) ? 0 : fpos;
    query[p] = fv;
    if (p + 1 < nf) begin
      fpos = p + 1;
      return 0;
    end
    fpos = 0;
    if (op == knn_pkg::OP_TRAIN) begin
      store_point(lab);
      return 0;
    end
    if (npts > ring_size() || oldest >= ring_size()) begin
      oldest = 0;
      npts = 0;
    end
    if (npts == 0) v = '{lbl: '0, nd: 1'b1};
    else v = '{lbl: vote_nearest(), nd: 1'b0};
    return 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, and the result side: stall pattern, checking, idle watchdog.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  int stall_mode, stall_left, idle_cycles;

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      // hold each stall mode for a random stretch: streaming, coin-flip, or mostly stalled
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 300);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase

      if (out_ch.valid && out_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected result word: label %0d no_data %0b", $time,
                   out_ch.predicted_label, out_ch.no_data);
          fails++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_ch.no_data !== want.nd) begin
            $display("%0t: no_data mismatch: expected %0b actual %0b", $time, want.nd,
                     out_ch.no_data);
            fails++;
          end
          if (out_ch.predicted_label !== want.lbl) begin
            $display("%0t: predicted_label mismatch: expected %0d actual %0d", $time,
                     want.lbl, out_ch.predicted_label);
            fails++;
          end
          n_verdicts++;
          if (want.nd) n_nodata++;
        end
      end

      // count cycles in which neither channel moves a word
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIM) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 pending_verdicts.size());
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: bursts with random gaps.
  // ---------------------------------------------------------------------------
  int burst_left;

  // Drive one word, hold it until accepted, then advance the shadow.
  task automatic send_word(logic [1:0] op, logic [15:0] fv, logic [3:0] lab,
                           bit typed = 0, verdict_t typed_v = '{lbl: '0, nd: 1'b0});
    int gap;
    verdict_t v;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.feature_value <= fv;
    in_ch.label         <= lab;
    do @(posedge clk); while (!in_ch.ready);
    n_words++;
    if (absorb_word(op, fv, lab, v)) pending_verdicts.push_back(typed ? typed_v : v);
  endtask

  // Drop valid and wait until every result is in and the store sweep has settled.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [knn_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[knn_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      knn_pkg::CFG_K: sh_k = val & 7'h7f;
      knn_pkg::CFG_NF: begin
        sh_nf = val & 4'hf;
        fpos = 0;
      end
      knn_pkg::CFG_CAP: begin
        sh_cap = val & 7'h7f;
        oldest = 0;
        npts = 0;
      end
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_feature();
    case ($urandom_range(0, 7)) inside
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3: return 16'($signed($urandom_range(0, 4)) - 2);  // small values force distance ties
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  drow_t dtab[$];

  initial begin
    int counted, phase_items, nf, pick, len, pct;
    logic [1:0] op;
    verdict_t tv;

    in_ch.valid = 1'b0;
    in_ch.operation = knn_pkg::OP_NONE;
    in_ch.feature_value = '0;
    in_ch.label = '0;
    cfg_we = 1'b0;
    cfg_index = knn_pkg::CFG_K;
    cfg_data = '0;
    rst_n = 1'b0;
    fails = 0;
    n_verdicts = 0;
    n_nodata = 0;
    n_trained = 0;
    n_words = 0;
    burst_left = 0;
    stall_left = 0;
    stall_mode = 0;
    sh_k = knn_pkg::K_RESET;
    sh_nf = knn_pkg::NF_RESET;
    sh_cap = knn_pkg::CAP_RESET;
    oldest = 0;
    npts = 0;
    fpos = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty store, feature extremes, both tie rules, clear, mixed
    // operations in one vector, and capacity wrap.
    dtab = '{
      '{0, knn_pkg::OP_NONE,    16'sd0,      4'd0,  0, 4'd0,  0},
      '{1, knn_pkg::CFG_NF,     16'sd1,      4'd0,  0, 4'd0,  0},
      '{0, knn_pkg::OP_PREDICT, 16'sd0,      4'd0,  1, 4'd0,  1},
      '{0, knn_pkg::OP_TRAIN,   -16'sd32768, 4'd15, 0, 4'd0,  0},
      '{0, knn_pkg::OP_TRAIN,   16'sd32767,  4'd5,  0, 4'd0,  0},
      '{0, knn_pkg::OP_PREDICT, -16'sd32768, 4'd0,  0, 4'd0,  0},
      '{1, knn_pkg::CFG_K,      16'sd1,      4'd0,  0, 4'd0,  0},
      '{0, knn_pkg::OP_PREDICT, -16'sd32768, 4'd0,  1, 4'd15, 0},
      '{0, knn_pkg::OP_PREDICT, 16'sd32767,  4'd0,  1, 4'd5,  0},
      '{0, knn_pkg::OP_TRAIN,   16'sd100,    4'd3,  0, 4'd0,  0},
      '{0, knn_pkg::OP_TRAIN,   16'sd100,    4'd2,  0, 4'd0,  0},
      '{0, knn_pkg::OP_PREDICT, 16'sd100,    4'd0,  0, 4'd0,  0},
      '{0, knn_pkg::OP_CLEAR,   16'sd0,      4'd0,  0, 4'd0,  0},
      '{0, knn_pkg::OP_PREDICT, 16'sd7,      4'd0,  1, 4'd0,  1},
      '{1, knn_pkg::CFG_NF,     16'sd2,      4'd0,  0, 4'd0,  0},
      '{0, knn_pkg::OP_PREDICT, 16'sd1,      4'd0,  0, 4'd0,  0},
      '{0, knn_pkg::OP_TRAIN,   16'sd2,      4'd9,  0, 4'd0,  0},
      '{0, knn_pkg::OP_TRAIN,   16'sd5,      4'd0,  0, 4'd0,  0},
      '{0, knn_pkg::OP_PREDICT, -16'sd5,     4'd0,  0, 4'd0,  0},
      '{1, knn_pkg::CFG_CAP,    16'sd1,      4'd0,  0, 4'd0,  0},
      '{0, knn_pkg::OP_TRAIN,   16'sd9,      4'd1,  0, 4'd0,  0},
      '{0, knn_pkg::OP_TRAIN,   16'sd9,      4'd4,  0, 4'd0,  0},
      '{0, knn_pkg::OP_TRAIN,   -16'sd9,     4'd7,  0, 4'd0,  0},
      '{0, knn_pkg::OP_TRAIN,   -16'sd9,     4'd8,  0, 4'd0,  0},
      '{0, knn_pkg::OP_PREDICT, 16'sd9,      4'd0,  0, 4'd0,  0},
      '{0, knn_pkg::OP_PREDICT, 16'sd9,      4'd0,  0, 4'd0,  0}
    };
    foreach (dtab[i]) begin
      if (dtab[i].is_cfg) begin
        write_reg(dtab[i].code, dtab[i].val);
      end else begin
        tv = '{lbl: dtab[i].exp_lbl, nd: dtab[i].exp_nd};
        send_word(dtab[i].code, dtab[i].val, dtab[i].lab, dtab[i].typed, tv);
      end
    end

    // Random phases; the first few pin the register extremes.
    counted = 0;
    for (int ph = 0; counted < RAND_ITEMS; ph++) begin
      case (ph)
        0: begin
          write_reg(knn_pkg::CFG_K, 64);
          write_reg(knn_pkg::CFG_NF, 8);
          write_reg(knn_pkg::CFG_CAP, 64);
        end
        1: begin
          write_reg(knn_pkg::CFG_K, 1);
          write_reg(knn_pkg::CFG_NF, 1);
          write_reg(knn_pkg::CFG_CAP, 1);
        end
        2: begin
          write_reg(knn_pkg::CFG_K, 0);
          write_reg(knn_pkg::CFG_NF, 0);
          write_reg(knn_pkg::CFG_CAP, 0);
        end
        3: begin
          write_reg(knn_pkg::CFG_K, 127);
          write_reg(knn_pkg::CFG_NF, 15);
          write_reg(knn_pkg::CFG_CAP, 127);
        end
        default: begin
          write_reg(knn_pkg::CFG_K, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                                : $urandom_range(1, 9));
          write_reg(knn_pkg::CFG_NF, $urandom_range(0, 15));
          write_reg(knn_pkg::CFG_CAP, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                                  : $urandom_range(1, 16));
        end
      endcase
      // keep predicts rare on a large ring, where each one walks the whole store
      pct = (ring_size() > 16) ? 6 : 35;
      phase_items = 0;
      while (phase_items < 130 && counted < RAND_ITEMS) begin
        nf = feat_in_use();
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          send_word(knn_pkg::OP_CLEAR, pick_feature(), 4'($urandom_range(0, 15)));
          phase_items++;
        end else if (pick < 6) begin
          send_word(knn_pkg::OP_NONE, pick_feature(), 4'($urandom_range(0, 15)));
        end else if (pick < 12) begin
          // broken vector: random operation per word, random length
          len = $urandom_range(1, nf);
          for (int w = 0; w < len; w++) begin
            op = ($urandom_range(0, 1) == 0) ? knn_pkg::OP_TRAIN : knn_pkg::OP_PREDICT;
            send_word(op, pick_feature(), 4'($urandom_range(0, 15)));
          end
          phase_items += len;
        end else begin
          op = ($urandom_range(0, 99) < pct) ? knn_pkg::OP_PREDICT : knn_pkg::OP_TRAIN;
          for (int w = 0; w < nf; w++) send_word(op, pick_feature(), 4'($urandom_range(0, 15)));
          phase_items += nf;
        end
        // midway through each phase hold the sender until every result is back
        if (phase_items >= 65 && phase_items < 65 + nf) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (pending_verdicts.size() != 0) @(posedge clk);
        end
      end
      counted += phase_items;
    end

    drain();
    $display("Covered %0d words, %0d vectors trained, %0d results (%0d on an empty store).",
             n_words, n_trained, n_verdicts, n_nodata);
    $display("Register extremes 0, max and above range were each exercised.");
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
